// File: hw/rtl/uart_frame_ingest_ring_fifo_macros.svh
// Assertion macros used by the frame ingest ring checker.
`ifndef UART_FRAME_INGEST_RING_FIFO_MACROS_SVH
`define UART_FRAME_INGEST_RING_FIFO_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UFI_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ufi assertion failed");

// Next-cycle implication, disabled during reset.
`define UFI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ufi assertion failed");

`endif

// File: hw/rtl/ufi_pkg.sv
// Package with types and constants of the UART frame ingest ring FIFO.
`timescale 1ns / 1ps

package ufi_pkg;

  localparam int unsigned RING_DEPTH_DEF = 256;
  localparam int unsigned MAX_FRAME_DEF  = 64;

  localparam logic [7:0]  SYNC_HI   = 8'h55;
  localparam logic [7:0]  SYNC_LO   = 8'haa;
  localparam logic [15:0] NO_SYNC   = 16'hffff;
  localparam logic [15:0] SYNC_WORD = 16'h55aa;
  localparam logic [15:0] LEN_MAX   = 16'hffff;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_POP   = 2'd1,
    OP_FLUSH = 2'd2,
    OP_EMPTY = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic        read_ok;
    logic        frame_done;
    logic [1:0]  frame_status;
    logic [15:0] frame_count;
    logic [15:0] byte_count;
    logic [15:0] last_length;
    logic [15:0] first_word;
    logic [15:0] sync_offset;
    logic [15:0] sync_word;
    logic [7:0]  queue_length;
  } out_beat_t;

endpackage

// File: hw/rtl/uart_frame_ingest_ring_fifo.sv
// Latency: result registered the cycle after acceptance; a held-byte pop goes via ST_READ.
// Throughput: one beat per cycle while not stalled by out_stall or the ST_READ state.
// The ring is one byte-wide memory with one registered read; it is never cleared.
// Reset (synchronous, active low) zeroes pointers, counters and reported fields,
// sets the sync offsets to all ones and clears the output valid; out_data is not reset.
`timescale 1ns / 1ps

module uart_frame_ingest_ring_fifo #(
  parameter int unsigned RING_DEPTH = ufi_pkg::RING_DEPTH_DEF,
  parameter int unsigned MAX_FRAME  = ufi_pkg::MAX_FRAME_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ufi_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ufi_pkg::out_beat_t  out_data
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam logic [15:0] MAX_LEN = 16'(MAX_FRAME);

  logic [7:0] ring_mem [RING_DEPTH];

  ufi_pkg::state_t state_r, state_nxt;

  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] stg_ptr_r, stg_ptr_nxt;
  logic [15:0]   pos_r, pos_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic [15:0]   stg_first_r, stg_first_nxt;
  logic [15:0]   stg_sync_r, stg_sync_nxt;
  logic [15:0]   frame_cnt_r, frame_cnt_nxt;
  logic [15:0]   byte_tot_r, byte_tot_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [15:0]   rep_len_r, rep_len_nxt;
  logic [15:0]   rep_first_r, rep_first_nxt;
  logic [15:0]   rep_sync_r, rep_sync_nxt;
  logic [15:0]   rep_word_r, rep_word_nxt;
  logic          out_valid_r, out_valid_nxt;
  ufi_pkg::out_beat_t out_data_r, out_data_nxt;
  logic [7:0]    rd_data_r;

  logic          accept;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] used;
  logic [15:0]   pos_inc;
  logic          done;
  logic          ok;

  assign in_stall  = (state_r != ufi_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign used      = stg_ptr_r - rd_ptr_r;
  assign pos_inc   = (pos_r != ufi_pkg::LEN_MAX) ? pos_r + 16'd1 : pos_r;

  always_comb begin
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    stg_ptr_nxt   = stg_ptr_r;
    pos_nxt       = pos_r;
    prev_nxt      = prev_r;
    stg_first_nxt = stg_first_r;
    stg_sync_nxt  = stg_sync_r;
    frame_cnt_nxt = frame_cnt_r;
    byte_tot_nxt  = byte_tot_r;
    status_nxt    = status_r;
    rep_len_nxt   = rep_len_r;
    rep_first_nxt = rep_first_r;
    rep_sync_nxt  = rep_sync_r;
    rep_word_nxt  = rep_word_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    done          = 1'b0;
    ok            = 1'b0;
    if (accept) begin
      case (ufi_pkg::opcode_t'(in_data.opcode))
        ufi_pkg::OP_BYTE: begin
          if ((pos_r < MAX_LEN) && (used != {AW{1'b1}})) begin
            mem_we      = 1'b1;
            stg_ptr_nxt = stg_ptr_r + AW'(1);
          end
          if (pos_r == 16'd0) begin
            stg_first_nxt = {in_data.data_byte, 8'h00};
          end else if (pos_r == 16'd1) begin
            stg_first_nxt = {stg_first_r[15:8], in_data.data_byte};
          end
          if ((stg_sync_r == ufi_pkg::NO_SYNC) && (pos_r != 16'd0) && (pos_r < MAX_LEN) &&
              (prev_r == ufi_pkg::SYNC_HI) && (in_data.data_byte == ufi_pkg::SYNC_LO)) begin
            stg_sync_nxt = pos_r - 16'd1;
          end
          prev_nxt = in_data.data_byte;
          pos_nxt  = pos_inc;
          if (in_data.last) begin
            done          = 1'b1;
            frame_cnt_nxt = frame_cnt_r + 16'd1;
            rep_len_nxt   = pos_inc;
            if (pos_inc > MAX_LEN) begin
              stg_ptr_nxt   = wr_ptr_r;
              status_nxt    = ufi_pkg::STAT_OVERFLOW;
              rep_first_nxt = 16'd0;
              rep_sync_nxt  = ufi_pkg::NO_SYNC;
              rep_word_nxt  = 16'd0;
            end else begin
              wr_ptr_nxt    = stg_ptr_nxt;
              byte_tot_nxt  = byte_tot_r + pos_inc;
              status_nxt    = ufi_pkg::STAT_OK;
              rep_first_nxt = stg_first_nxt;
              rep_sync_nxt  = stg_sync_nxt;
              rep_word_nxt  = (stg_sync_nxt != ufi_pkg::NO_SYNC) ? ufi_pkg::SYNC_WORD : 16'd0;
            end
            pos_nxt       = 16'd0;
            prev_nxt      = 8'd0;
            stg_first_nxt = 16'd0;
            stg_sync_nxt  = ufi_pkg::NO_SYNC;
          end
        end
        ufi_pkg::OP_POP: begin
          if (wr_ptr_r != rd_ptr_r) begin
            mem_re     = 1'b1;
            ok         = 1'b1;
            rd_ptr_nxt = rd_ptr_r + AW'(1);
          end
        end
        ufi_pkg::OP_FLUSH: begin
          rd_ptr_nxt  = '0;
          wr_ptr_nxt  = '0;
          stg_ptr_nxt = '0;
        end
        ufi_pkg::OP_EMPTY: begin
          stg_ptr_nxt   = wr_ptr_r;
          pos_nxt       = 16'd0;
          prev_nxt      = 8'd0;
          stg_first_nxt = 16'd0;
          stg_sync_nxt  = ufi_pkg::NO_SYNC;
          done          = 1'b1;
          frame_cnt_nxt = frame_cnt_r + 16'd1;
          status_nxt    = ufi_pkg::STAT_EMPTY;
          rep_len_nxt   = 16'd0;
          rep_first_nxt = 16'd0;
          rep_sync_nxt  = ufi_pkg::NO_SYNC;
          rep_word_nxt  = 16'd0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      ufi_pkg::ST_IDLE: begin
        if (accept) begin
          out_data_nxt.read_byte    = 8'd0;
          out_data_nxt.read_ok      = ok;
          out_data_nxt.frame_done   = done;
          out_data_nxt.frame_status = status_nxt;
          out_data_nxt.frame_count  = frame_cnt_nxt;
          out_data_nxt.byte_count   = byte_tot_nxt;
          out_data_nxt.last_length  = rep_len_nxt;
          out_data_nxt.first_word   = rep_first_nxt;
          out_data_nxt.sync_offset  = rep_sync_nxt;
          out_data_nxt.sync_word    = rep_word_nxt;
          out_data_nxt.queue_length = 8'(AW'(wr_ptr_nxt - rd_ptr_nxt));
          if (mem_re) begin
            state_nxt = ufi_pkg::ST_READ;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ufi_pkg::ST_READ: begin
        out_data_nxt.read_byte = rd_data_r;
        out_valid_nxt          = 1'b1;
        state_nxt              = ufi_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ufi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[stg_ptr_r] <= in_data.data_byte;
    end
    if (mem_re) begin
      rd_data_r <= ring_mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ufi_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      stg_ptr_r   <= '0;
      pos_r       <= 16'd0;
      prev_r      <= 8'd0;
      stg_first_r <= 16'd0;
      stg_sync_r  <= ufi_pkg::NO_SYNC;
      frame_cnt_r <= 16'd0;
      byte_tot_r  <= 16'd0;
      status_r    <= ufi_pkg::STAT_OK;
      rep_len_r   <= 16'd0;
      rep_first_r <= 16'd0;
      rep_sync_r  <= ufi_pkg::NO_SYNC;
      rep_word_r  <= 16'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      stg_ptr_r   <= stg_ptr_nxt;
      pos_r       <= pos_nxt;
      prev_r      <= prev_nxt;
      stg_first_r <= stg_first_nxt;
      stg_sync_r  <= stg_sync_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      byte_tot_r  <= byte_tot_nxt;
      status_r    <= status_nxt;
      rep_len_r   <= rep_len_nxt;
      rep_first_r <= rep_first_nxt;
      rep_sync_r  <= rep_sync_nxt;
      rep_word_r  <= rep_word_nxt;
    end
  end

endmodule

// File: hw/rtl/ufi_checker.sv
// Port-level checker for the UART frame ingest ring FIFO, with its bind.
`timescale 1ns / 1ps
`include "uart_frame_ingest_ring_fifo_macros.svh"

module ufi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input ufi_pkg::in_beat_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input ufi_pkg::out_beat_t out_data
);

  logic in_acc;
  logic out_hold;
  logic acc_mid_byte;
  logic acc_empty_evt;
  logic empty_report;

  assign in_acc        = in_valid && !in_stall;
  assign out_hold      = out_valid && out_stall;
  assign acc_mid_byte  = in_acc && (in_data.opcode == ufi_pkg::OP_BYTE) && !in_data.last;
  assign acc_empty_evt = in_acc && (in_data.opcode == ufi_pkg::OP_EMPTY);
  assign empty_report  = out_valid && out_data.frame_done &&
                         (out_data.frame_status == ufi_pkg::STAT_EMPTY) &&
                         (out_data.last_length == 16'd0) &&
                         (out_data.sync_offset == ufi_pkg::NO_SYNC);

  `UFI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_hold, out_valid && $stable(out_data))
  `UFI_ASSERT_NEXT(a_mid_byte_result, clk, rst_n, acc_mid_byte, out_valid && !out_data.frame_done && !out_data.read_ok)
  `UFI_ASSERT_NEXT(a_empty_event_result, clk, rst_n, acc_empty_evt, empty_report)
  `UFI_ASSERT_NOW(a_no_read_no_byte, clk, rst_n, out_valid && !out_data.read_ok, out_data.read_byte == 8'd0)

endmodule

bind uart_frame_ingest_ring_fifo ufi_checker u_ufi_checker (.*);

// File: test/uart_frame_ingest_ring_fifo_tb.sv
// Self-checking testbench for the UART frame ingest ring FIFO with a scoreboard class.
`timescale 1ns / 1ps

module uart_frame_ingest_ring_fifo_tb;
  import ufi_pkg::*;

  localparam int unsigned MAX_FRAME = MAX_FRAME_DEF;
  localparam int RANDOM_BEATS = 1600;

  class frame_ring_scoreboard;
    logic [7:0]  ring_bytes [256];
    logic [7:0]  rd_ptr;
    logic [7:0]  wr_ptr;
    logic [7:0]  stage_ptr;
    logic [15:0] frame_pos;
    logic [7:0]  prev_byte;
    logic [15:0] stage_first;
    logic [15:0] stage_sync;
    logic [15:0] frames_seen;
    logic [15:0] good_bytes;
    logic [1:0]  held_status;
    logic [15:0] held_length;
    logic [15:0] held_first;
    logic [15:0] held_sync_offset;
    logic [15:0] held_sync_word;
    out_beat_t   pending_results [$];
    int          errors;

    function new();
      rd_ptr = '0;
      wr_ptr = '0;
      stage_ptr = '0;
      frames_seen = '0;
      good_bytes = '0;
      held_status = STAT_OK;
      held_length = '0;
      held_first = '0;
      held_sync_offset = NO_SYNC;
      held_sync_word = '0;
      errors = 0;
      clear_tracking();
    endfunction

    function void clear_tracking();
      frame_pos = '0;
      prev_byte = '0;
      stage_first = '0;
      stage_sync = NO_SYNC;
    endfunction

    function void report_fault(status_t status, logic [15:0] length);
      held_status = status;
      held_length = length;
      held_first = '0;
      held_sync_offset = NO_SYNC;
      held_sync_word = '0;
    endfunction

    function void note_beat(in_beat_t beat);
      out_beat_t   expected;
      logic [15:0] pos;
      logic [7:0]  used;
      logic [15:0] length;
      expected = '0;
      case (opcode_t'(beat.opcode))
        OP_BYTE: begin
          pos = frame_pos;
          used = stage_ptr - rd_ptr;
          if (pos < MAX_FRAME && used != 8'hff) begin
            ring_bytes[stage_ptr] = beat.data_byte;
            stage_ptr = stage_ptr + 8'd1;
          end
          if (pos == 16'd0) begin
            stage_first = {beat.data_byte, 8'h00};
          end else if (pos == 16'd1) begin
            stage_first[7:0] = beat.data_byte;
          end
          if (stage_sync == NO_SYNC && pos >= 16'd1 && pos < MAX_FRAME &&
              prev_byte == SYNC_HI && beat.data_byte == SYNC_LO) begin
            stage_sync = pos - 16'd1;
          end
          prev_byte = beat.data_byte;
          if (frame_pos != LEN_MAX) begin
            frame_pos = frame_pos + 16'd1;
          end
          if (beat.last) begin
            length = frame_pos;
            expected.frame_done = 1'b1;
            frames_seen = frames_seen + 16'd1;
            if (length > MAX_FRAME) begin
              stage_ptr = wr_ptr;
              report_fault(STAT_OVERFLOW, length);
            end else begin
              wr_ptr = stage_ptr;
              good_bytes = good_bytes + length;
              held_status = STAT_OK;
              held_length = length;
              held_first = stage_first;
              held_sync_offset = stage_sync;
              held_sync_word = (stage_sync != NO_SYNC) ? SYNC_WORD : 16'h0000;
            end
            clear_tracking();
          end
        end
        OP_POP: begin
          if (wr_ptr != rd_ptr) begin
            expected.read_byte = ring_bytes[rd_ptr];
            expected.read_ok = 1'b1;
            rd_ptr = rd_ptr + 8'd1;
          end
        end
        OP_FLUSH: begin
          rd_ptr = '0;
          wr_ptr = '0;
          stage_ptr = '0;
        end
        default: begin
          stage_ptr = wr_ptr;
          clear_tracking();
          expected.frame_done = 1'b1;
          frames_seen = frames_seen + 16'd1;
          report_fault(STAT_EMPTY, 16'd0);
        end
      endcase
      expected.frame_status = held_status;
      expected.frame_count = frames_seen;
      expected.byte_count = good_bytes;
      expected.last_length = held_length;
      expected.first_word = held_first;
      expected.sync_offset = held_sync_offset;
      expected.sync_word = held_sync_word;
      expected.queue_length = wr_ptr - rd_ptr;
      pending_results.push_back(expected);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with no expectation, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("read_byte", 16'(want.read_byte), 16'(got.read_byte));
      compare_field("read_ok", 16'(want.read_ok), 16'(got.read_ok));
      compare_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
      compare_field("frame_status", 16'(want.frame_status), 16'(got.frame_status));
      compare_field("frame_count", want.frame_count, got.frame_count);
      compare_field("byte_count", want.byte_count, got.byte_count);
      compare_field("last_length", want.last_length, got.last_length);
      compare_field("first_word", want.first_word, got.first_word);
      compare_field("sync_offset", want.sync_offset, got.sync_offset);
      compare_field("sync_word", want.sync_word, got.sync_word);
      compare_field("queue_length", 16'(want.queue_length), 16'(got.queue_length));
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  frame_ring_scoreboard frame_board = new();
  bit quiet = 1'b1;
  int beats_sent = 0;
  int stall_left = 0;

  uart_frame_ingest_ring_fifo DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1: return SYNC_HI;
      2, 3: return SYNC_LO;
      4: return 8'h00;
      5: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left <= idle_length();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      frame_board.check_result(out_data);
    end
  end

  task automatic send_beat(opcode_t op, logic [7:0] data, logic last);
    in_beat_t beat;
    int gap;
    beat.opcode = op;
    beat.data_byte = data;
    beat.last = last;
    gap = quiet ? 0 : idle_length();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
    frame_board.note_beat(beat);
    beats_sent++;
  endtask

  task automatic send_frame(int length, bit interrupt);
    int sync_at;
    int cut_at;
    logic [7:0] data;
    sync_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, length) : -2;
    cut_at = interrupt ? $urandom_range(0, length - 1) : -1;
    for (int i = 0; i < length; i++) begin
      if (i == cut_at) begin
        send_beat(opcode_t'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end
      if (i == sync_at) data = SYNC_HI;
      else if (i == sync_at + 1) data = SYNC_LO;
      else data = pick_byte();
      send_beat(OP_BYTE, data, i == length - 1);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frame_board.pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int target;
    int length;
    int pop_weight;
    int pick;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_beat(OP_POP, 8'hff, 1'b1);
    send_beat(OP_EMPTY, 8'h00, 1'b0);
    send_beat(OP_BYTE, 8'hff, 1'b1);
    send_beat(OP_BYTE, SYNC_HI, 1'b0);
    send_beat(OP_BYTE, SYNC_LO, 1'b0);
    send_beat(OP_BYTE, 8'h00, 1'b1);
    send_beat(OP_BYTE, 8'h00, 1'b0);
    send_beat(OP_BYTE, SYNC_HI, 1'b0);
    send_beat(OP_BYTE, SYNC_LO, 1'b1);
    send_beat(OP_POP, 8'h00, 1'b0);
    send_beat(OP_POP, 8'h00, 1'b1);
    send_beat(OP_FLUSH, 8'hff, 1'b1);
    send_beat(OP_BYTE, 8'h12, 1'b0);
    send_beat(OP_BYTE, 8'h34, 1'b0);
    send_beat(OP_FLUSH, 8'h00, 1'b0);
    send_beat(OP_BYTE, 8'h56, 1'b1);
    send_beat(OP_POP, 8'h00, 1'b0);
    send_beat(OP_POP, 8'h00, 1'b0);
    send_beat(OP_BYTE, SYNC_HI, 1'b0);
    send_beat(OP_EMPTY, 8'hff, 1'b1);
    send_beat(OP_POP, 8'h00, 1'b0);
    send_beat(OP_BYTE, 8'h7e, 1'b1);
    send_beat(OP_POP, 8'h00, 1'b1);
    wait_drained();

    target = beats_sent + RANDOM_BEATS;
    while (beats_sent < target) begin
      quiet = ($urandom_range(0, 5) == 0);
      pop_weight = $urandom_range(0, 3);
      repeat ($urandom_range(3, 10)) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          pick = $urandom_range(0, 99);
          if (pick < 65) length = $urandom_range(1, 8);
          else if (pick < 88) length = $urandom_range(9, MAX_FRAME);
          else if (pick < 94) length = MAX_FRAME + $urandom_range(0, 1);
          else length = $urandom_range(MAX_FRAME + 1, MAX_FRAME + 16);
          send_frame(length, $urandom_range(0, 11) == 0);
        end else if (pick < 88) begin
          repeat (pop_weight * $urandom_range(0, 6)) begin
            send_beat(OP_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          end
        end else if (pick < 92) begin
          send_beat(OP_FLUSH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else if (pick < 96) begin
          send_beat(OP_EMPTY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
          send_beat(opcode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        end
      end
    end
    quiet = 1'b0;
    wait_drained();

    quiet = 1'b1;
    send_beat(OP_FLUSH, 8'h00, 1'b0);
    for (int f = 0; f < 5; f++) begin
      send_frame(MAX_FRAME, 1'b0);
    end
    quiet = 1'b0;
    repeat (40) send_beat(OP_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (frame_board.errors == 0 && frame_board.pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
